// ===== src/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Shared widths, op codes and status codes for the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Payload field widths
  localparam int OP_W        = 2;
  localparam int LED_W       = 16;
  localparam int HOLD_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_CNT_W = 7;
  localparam int CUR_ENTRY_W = 6;

  // Configuration register
  localparam int LED_CNT_W   = 5;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // LEDs the drive logic can serve; an active LED count above this is clamped
  localparam int MAX_LEDS    = 16;

  // Table depth default
  localparam int TABLE_DEPTH = 64;

  // Op codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_HOLD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Register word index (paddr[2])
  localparam logic REG_ACTIVE_LEDS = 1'b0;

  typedef logic [LED_W-1:0]  pattern_t;
  typedef logic [HOLD_W-1:0] hold_t;

  // One table entry as stored in RAM
  typedef struct packed {
    hold_t    hold;
    pattern_t pattern;
  } entry_t;

endpackage

// ===== src/lps_ram.sv =====
// ----------------------------------------------------------------------------
// lps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/led_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_pattern_sequencer
// Plays a table of LED patterns, each held for a number of ticks.
// ----------------------------------------------------------------------------
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  -------------------------
//  input    in_op, in_led_pattern, in_hold_ticks    start high, busy low
//  result   out_led_out, out_status, out_running,   out_valid, one cycle,
//           out_entry_count, out_current_entry      no backpressure
//  config   psel, penable, pwrite, paddr, pwdata,   APB, pready tied high
//           prdata, pready
//
// One item per clock; busy never rises. The result of an item shows on the
// cycle after its beat. The entry after the current one is prefetched
// through the RAM's registered read port, so a step to the next entry needs
// no wait. rst_n is synchronous and clears control state only; table
// contents are undefined until appended. The receiver cannot stall.
// ----------------------------------------------------------------------------
module led_pattern_sequencer #(
  parameter int TABLE_DEPTH = lps_pkg::TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           start,
  output logic                           busy,
  input  logic [lps_pkg::OP_W-1:0]       in_op,
  input  logic [lps_pkg::LED_W-1:0]      in_led_pattern,
  input  logic [lps_pkg::HOLD_W-1:0]     in_hold_ticks,
  // result channel
  output logic                           out_valid,
  output logic [lps_pkg::LED_W-1:0]      out_led_out,
  output logic [lps_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_running,
  output logic [lps_pkg::ENTRY_CNT_W-1:0] out_entry_count,
  output logic [lps_pkg::CUR_ENTRY_W-1:0] out_current_entry,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lps_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lps_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = $bits(lps_pkg::entry_t);

  // Control state
  logic [CNT_W-1:0]               stored_r, stored_nxt;
  logic [IDX_W-1:0]               cursor_r, cursor_nxt;
  lps_pkg::hold_t                 ticks_r, ticks_nxt;
  logic                           playing_r, playing_nxt;
  logic [lps_pkg::LED_CNT_W-1:0]  active_leds_r;
  logic                           out_valid_r;
  logic                           byp_hit_r, byp_hit_nxt;

  // Payload state
  lps_pkg::pattern_t              cur_pat_r, cur_pat_nxt;
  lps_pkg::entry_t                e0_r, e0_nxt;
  lps_pkg::entry_t                byp_data_r;

  logic [lps_pkg::LED_W-1:0]       led_out_r;
  logic [lps_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                            running_r;
  logic [lps_pkg::ENTRY_CNT_W-1:0] entry_count_r;
  logic [lps_pkg::CUR_ENTRY_W-1:0] current_entry_r;

  // RAM port signals
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  lps_pkg::entry_t      ram_wdata, ram_rdata, next_entry;

  logic                 accept, is_append, append_ok, hold_zero, table_full;
  logic                 wrap;
  lps_pkg::hold_t       ticks_dec;
  logic [lps_pkg::LED_W-1:0] led_mask;
  logic                 cfg_wr;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  assign is_append  = accept && (in_op == lps_pkg::OP_APPEND);
  assign hold_zero  = (in_hold_ticks == '0);
  assign table_full = (stored_r >= CNT_W'(TABLE_DEPTH));
  assign append_ok  = is_append && !hold_zero && !table_full;

  // Entry after the cursor: bypass when it was written in the fetch cycle
  assign next_entry = byp_hit_r ? byp_data_r : ram_rdata;
  assign wrap       = ((CNT_W'(cursor_r) + CNT_W'(1)) >= stored_r);
  assign ticks_dec  = (ticks_r != '0) ? (ticks_r - lps_pkg::hold_t'(1)) : ticks_r;

  always_comb begin
    stored_nxt  = stored_r;
    cursor_nxt  = cursor_r;
    ticks_nxt   = ticks_r;
    playing_nxt = playing_r;
    cur_pat_nxt = cur_pat_r;
    e0_nxt      = e0_r;
    status_nxt  = lps_pkg::ST_OK;

    if (accept) begin
      unique case (in_op)
        lps_pkg::OP_APPEND: begin
          if (hold_zero) begin
            status_nxt = lps_pkg::ST_ZERO_HOLD;
          end else if (table_full) begin
            status_nxt = lps_pkg::ST_FULL;
          end else begin
            stored_nxt = stored_r + CNT_W'(1);
            // Idle table is empty, so the new entry is entry 0
            if (!playing_r) begin
              playing_nxt    = 1'b1;
              cursor_nxt     = '0;
              ticks_nxt      = in_hold_ticks;
              cur_pat_nxt    = in_led_pattern;
              e0_nxt.hold    = in_hold_ticks;
              e0_nxt.pattern = in_led_pattern;
            end
          end
        end
        lps_pkg::OP_CLEAR: begin
          playing_nxt = 1'b0;
          stored_nxt  = '0;
          cursor_nxt  = '0;
          ticks_nxt   = '0;
        end
        lps_pkg::OP_TICK: begin
          if (playing_r && (stored_r != '0)) begin
            if (ticks_dec == '0) begin
              if (wrap) begin
                cursor_nxt  = '0;
                ticks_nxt   = e0_r.hold;
                cur_pat_nxt = e0_r.pattern;
              end else begin
                cursor_nxt  = cursor_r + IDX_W'(1);
                ticks_nxt   = next_entry.hold;
                cur_pat_nxt = next_entry.pattern;
              end
            end else begin
              ticks_nxt = ticks_dec;
            end
          end
        end
        default: begin
          // unused op: report state only
        end
      endcase
    end
  end

  // Prefetch the entry after the next cursor
  assign ram_raddr = (cursor_nxt == IDX_W'(TABLE_DEPTH - 1)) ? '0
                                                             : cursor_nxt + IDX_W'(1);
  assign ram_we    = append_ok;
  assign ram_waddr = stored_r[IDX_W-1:0];
  assign ram_wdata = '{hold: in_hold_ticks, pattern: in_led_pattern};
  assign byp_hit_nxt = ram_we && (ram_waddr == ram_raddr);

  lps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Drive off LEDs at or above the clamped count
  always_comb begin
    for (int i = 0; i < lps_pkg::LED_W; i++) begin
      led_mask[i] = (lps_pkg::LED_CNT_W'(i) < active_leds_r) && (i < lps_pkg::MAX_LEDS);
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {{(lps_pkg::APB_DATA_W - lps_pkg::LED_CNT_W){1'b0}}, active_leds_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r      <= '0;
      cursor_r      <= '0;
      ticks_r       <= '0;
      playing_r     <= 1'b0;
      active_leds_r <= '0;
      out_valid_r   <= 1'b0;
      byp_hit_r     <= 1'b0;
    end else begin
      stored_r    <= stored_nxt;
      cursor_r    <= cursor_nxt;
      ticks_r     <= ticks_nxt;
      playing_r   <= playing_nxt;
      out_valid_r <= accept;
      byp_hit_r   <= byp_hit_nxt;
      if (cfg_wr && (paddr[2] == lps_pkg::REG_ACTIVE_LEDS)) begin
        active_leds_r <= pwdata[lps_pkg::LED_CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_pat_r       <= cur_pat_nxt;
    e0_r            <= e0_nxt;
    byp_data_r      <= ram_wdata;
    status_r        <= status_nxt;
    led_out_r       <= playing_nxt ? (cur_pat_nxt & led_mask) : '0;
    running_r       <= playing_nxt;
    entry_count_r   <= lps_pkg::ENTRY_CNT_W'(stored_nxt);
    current_entry_r <= playing_nxt ? lps_pkg::CUR_ENTRY_W'(cursor_nxt) : '0;
  end

  assign out_valid         = out_valid_r;
  assign out_led_out       = led_out_r;
  assign out_status        = status_r;
  assign out_running       = running_r;
  assign out_entry_count   = entry_count_r;
  assign out_current_entry = current_entry_r;

endmodule
